// ----- rtl/core/french_number_word_tokenizer_macros.svh -----
// Assertion macros for the tokenizer checker.
`ifndef FRENCH_NUMBER_WORD_TOKENIZER_MACROS_SVH
`define FRENCH_NUMBER_WORD_TOKENIZER_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define FNW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define FNW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fnw_pkg.sv -----
// Package: word codes, group entry type and word tables for the tokenizer.
package fnw_pkg;

	typedef logic [5:0] word_t;

	localparam int NSLOT = 9;
	localparam int SLOT_VIDE = NSLOT - 1;

	localparam word_t W_PLUS      = 6'd0;
	localparam word_t W_VIDE      = 6'd1;
	localparam word_t W_ZERO      = 6'd2;
	localparam word_t W_MILLE     = 6'd3;
	localparam word_t W_DEUX      = 6'd4;
	localparam word_t W_TROIS     = 6'd5;
	localparam word_t W_QUATRE    = 6'd6;
	localparam word_t W_CINQ      = 6'd7;
	localparam word_t W_SI        = 6'd8;
	localparam word_t W_SEPT      = 6'd9;
	localparam word_t W_HUI       = 6'd10;
	localparam word_t W_NEUF      = 6'd11;
	localparam word_t W_CENT      = 6'd12;
	localparam word_t W_VINGT     = 6'd13;
	localparam word_t W_VINGTT    = 6'd14;
	localparam word_t W_EH        = 6'd15;
	localparam word_t W_TRENTE    = 6'd16;
	localparam word_t W_QUARANTE  = 6'd17;
	localparam word_t W_CINQUANTE = 6'd18;
	localparam word_t W_SOIXANTE  = 6'd19;
	localparam word_t W_QUATREE   = 6'd20;
	localparam word_t W_DIX       = 6'd21;
	localparam word_t W_ONZE      = 6'd22;
	localparam word_t W_UN        = 6'd23;
	localparam word_t W_DOUZE     = 6'd24;
	localparam word_t W_TREIZE    = 6'd25;
	localparam word_t W_QUATORZE  = 6'd26;
	localparam word_t W_QUINZE    = 6'd27;
	localparam word_t W_SEIZE     = 6'd28;
	localparam word_t W_SIX       = 6'd29;
	localparam word_t W_DI        = 6'd30;
	localparam word_t W_DIZ       = 6'd31;
	localparam word_t W_HUIT      = 6'd32;

	// One classified group: a word per slot, a mask of spoken slots, message end flag.
	typedef struct packed {
		word_t [NSLOT-1:0] codes;
		logic [NSLOT-1:0]  mask;
		logic              fin;
	} grp_t;

	// Word spoken before mille or cent, digits 2..9.
	function automatic word_t lead_word(input logic [3:0] d);
		word_t w;
		unique case (d)
			4'd2: w = W_DEUX;
			4'd3: w = W_TROIS;
			4'd4: w = W_QUATRE;
			4'd5: w = W_CINQ;
			4'd6: w = W_SI;
			4'd7: w = W_SEPT;
			4'd8: w = W_HUI;
			4'd9: w = W_NEUF;
			default: w = W_VIDE;
		endcase
		return w;
	endfunction

	// Tens words for tens digits 3..6.
	function automatic word_t tens_word(input logic [3:0] d);
		word_t w;
		unique case (d)
			4'd3: w = W_TRENTE;
			4'd4: w = W_QUARANTE;
			4'd5: w = W_CINQUANTE;
			4'd6: w = W_SOIXANTE;
			default: w = W_VIDE;
		endcase
		return w;
	endfunction

	// Plain units 1..9.
	function automatic word_t unit_plain(input logic [3:0] d);
		word_t w;
		unique case (d)
			4'd1: w = W_UN;
			4'd2: w = W_DEUX;
			4'd3: w = W_TROIS;
			4'd4: w = W_QUATRE;
			4'd5: w = W_CINQ;
			4'd6: w = W_SIX;
			4'd7: w = W_SEPT;
			4'd8: w = W_HUIT;
			4'd9: w = W_NEUF;
			default: w = W_VIDE;
		endcase
		return w;
	endfunction

	// Teen forms for units 1..6.
	function automatic word_t unit_teen(input logic [3:0] d);
		word_t w;
		unique case (d)
			4'd1: w = W_ONZE;
			4'd2: w = W_DOUZE;
			4'd3: w = W_TREIZE;
			4'd4: w = W_QUATORZE;
			4'd5: w = W_QUINZE;
			4'd6: w = W_SEIZE;
			default: w = W_VIDE;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/fnw_front.sv -----
// Front end: classify one digit group into per-slot word codes.
module fnw_front import fnw_pkg::*; (
	input  logic       is_plus,
	input  logic [2:0] digit_count,
	input  logic [3:0] thousands_digit,
	input  logic [3:0] hundreds_digit,
	input  logic [3:0] tens_digit,
	input  logic [3:0] units_digit,
	input  logic       final_group,
	output logic       good,
	output grp_t       grp
);

	logic th_p, hu_p, te_p;
	logic zt, zh, zte;
	logic teen;
	logic [3:0] th, hu, te, un;

	always_comb begin
		th = thousands_digit;
		hu = hundreds_digit;
		te = tens_digit;
		un = units_digit;
		th_p = (digit_count == 3'd4);
		hu_p = (digit_count >= 3'd3);
		te_p = (digit_count >= 3'd2);
		zt  = !th_p || (th == 4'd0);
		zh  = zt && (!hu_p || (hu == 4'd0));
		zte = zh && (!te_p || (te == 4'd0));
		good = is_plus || ((digit_count >= 3'd1) && (digit_count <= 3'd4));
		teen = 1'b0;

		grp.fin = final_group;
		grp.mask = '0;
		for (int i = 0; i < NSLOT; i++) begin
			grp.codes[i] = W_VIDE;
		end
		grp.mask[SLOT_VIDE] = 1'b1;

		if (is_plus) begin
			grp.codes[0] = W_PLUS;
			grp.mask[0] = 1'b1;
		end else begin
			// thousands position
			if (th_p) begin
				if (th == 4'd0) begin
					grp.codes[0] = W_ZERO;
					grp.mask[0] = 1'b1;
				end else if (th <= 4'd9) begin
					grp.codes[0] = lead_word(th);
					grp.mask[0] = (th != 4'd1);
					grp.codes[1] = W_MILLE;
					grp.mask[1] = 1'b1;
				end
			end
			// hundreds position
			if (hu_p) begin
				if (hu == 4'd0) begin
					grp.codes[2] = W_ZERO;
					grp.mask[2] = zt;
				end else if (hu <= 4'd9) begin
					grp.codes[2] = lead_word(hu);
					grp.mask[2] = (hu != 4'd1);
					grp.codes[3] = W_CENT;
					grp.mask[3] = 1'b1;
				end
			end
			// tens position
			if (te_p) begin
				if (te == 4'd0) begin
					grp.codes[4] = W_ZERO;
					grp.mask[4] = zh;
				end else if (te == 4'd1) begin
					teen = 1'b1;
				end else if (te == 4'd2) begin
					grp.codes[4] = (un == 4'd0) ? W_VINGT : W_VINGTT;
					grp.mask[4] = 1'b1;
					grp.codes[5] = W_EH;
					grp.mask[5] = (un == 4'd1);
				end else if (te <= 4'd7) begin
					grp.codes[4] = (te == 4'd7) ? W_SOIXANTE : tens_word(te);
					grp.mask[4] = 1'b1;
					grp.codes[5] = W_EH;
					grp.mask[5] = (un == 4'd1);
					teen = (te == 4'd7);
				end else if (te <= 4'd9) begin
					grp.codes[4] = W_QUATREE;
					grp.mask[4] = 1'b1;
					grp.codes[5] = W_VINGT;
					grp.mask[5] = 1'b1;
					teen = (te == 4'd9);
				end
			end
			// units position
			if (un == 4'd0) begin
				grp.codes[6] = W_ZERO;
				grp.mask[6] = zte;
				grp.codes[7] = W_DIX;
				grp.mask[7] = teen;
			end else if (un <= 4'd6) begin
				grp.codes[7] = teen ? unit_teen(un) : unit_plain(un);
				grp.mask[7] = 1'b1;
			end else if (un <= 4'd9) begin
				grp.codes[6] = (un == 4'd7) ? W_DI : W_DIZ;
				grp.mask[6] = teen;
				grp.codes[7] = unit_plain(un);
				grp.mask[7] = 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/fnw_queue.sv -----
// Two-entry queue of classified groups between front and back.
module fnw_queue import fnw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_grp,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output grp_t head_grp
);

	grp_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_grp   = mem_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// write entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_grp;
	end

endmodule

// ----- rtl/core/fnw_back.sv -----
// Back end: walk a group's spoken slots and emit one word per transfer.
module fnw_back import fnw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  grp_t        head_grp,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  word_code,
	output logic        last_of_group,
	output logic        end_of_message
);

	word_t [NSLOT-1:0] codes_q;
	logic [NSLOT-1:0]  mask_q;
	logic              fin_q;
	logic              out_valid_q;
	word_t             code_q;
	logic              last_q, eom_q;

	logic              adv, take;
	logic [3:0]        sel_idx;
	logic [NSLOT-1:0]  mask_next;

	// pick the lowest spoken slot
	always_comb begin
		sel_idx = 4'd0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) sel_idx = 4'(i);
		end
		adv = !out_valid_q || out_ready;
		take = adv && (mask_q != '0);
		mask_next = take ? (mask_q & (mask_q - NSLOT'(1))) : mask_q;
		pop = head_valid && (mask_next == '0);
	end

	// hold the working group, refill from the queue when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else begin
			mask_q <= pop ? head_grp.mask : mask_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			codes_q <= head_grp.codes;
			fin_q   <= head_grp.fin;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_q <= codes_q[sel_idx];
			last_q <= (sel_idx == 4'(SLOT_VIDE));
			eom_q  <= (sel_idx == 4'(SLOT_VIDE)) && fin_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign word_code      = code_q;
	assign last_of_group  = last_q;
	assign end_of_message = eom_q;

endmodule

// ----- rtl/core/french_number_word_tokenizer.sv -----
// A group's first word passes the queue, the working group and the output register.
// Throughput: one word per cycle while out_ready is high; words drain through the single
//   output register, and groups follow without gaps.
// Input ready falls only when the two-entry group queue is full.
// Reset (arst_n low, asynchronous) empties the queue, the working group and the output.
// Non-plus groups with a digit count outside 1..4 are taken and produce no words.
module french_number_word_tokenizer import fnw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       is_plus,
	input  logic [2:0] digit_count,
	input  logic [3:0] thousands_digit,
	input  logic [3:0] hundreds_digit,
	input  logic [3:0] tens_digit,
	input  logic [3:0] units_digit,
	input  logic       final_group,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] word_code,
	output logic       last_of_group,
	output logic       end_of_message
);

	logic good, full, head_valid, pop, push;
	grp_t front_grp, head_grp;

	assign in_ready = !full;
	assign push = in_valid && in_ready && good;

	fnw_front u_front (
		.is_plus         (is_plus),
		.digit_count     (digit_count),
		.thousands_digit (thousands_digit),
		.hundreds_digit  (hundreds_digit),
		.tens_digit      (tens_digit),
		.units_digit     (units_digit),
		.final_group     (final_group),
		.good            (good),
		.grp             (front_grp)
	);

	fnw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (front_grp),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_grp   (head_grp)
	);

	fnw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_grp       (head_grp),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_code      (word_code),
		.last_of_group  (last_of_group),
		.end_of_message (end_of_message)
	);

endmodule

// ----- rtl/core/fnw_checker.sv -----
// Port-level checker for the tokenizer, bound to the top level.
`include "french_number_word_tokenizer_macros.svh"

module fnw_checker import fnw_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] word_code,
	input logic       last_of_group,
	input logic       end_of_message
);

	// a stalled word holds
	`FNW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_code) && $stable(last_of_group) && $stable(end_of_message), "output changed while stalled")

	// message end only on a group close
	`FNW_ASSERT(a_eom_last, !(out_valid && end_of_message) || last_of_group, "end of message without group close")

	// group close is always the silence word
	`FNW_ASSERT(a_last_vide, !(out_valid && last_of_group) || (word_code == W_VIDE), "group close is not silence")

	// plus is followed at once by the closing silence
	`FNW_ASSERT_NEXT(a_plus_vide, out_valid && out_ready && (word_code == W_PLUS), out_valid && (word_code == W_VIDE) && last_of_group, "plus not followed by silence")

endmodule

bind french_number_word_tokenizer fnw_checker u_fnw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.word_code      (word_code),
	.last_of_group  (last_of_group),
	.end_of_message (end_of_message)
);

// ----- tb/tb_french_number_word_tokenizer.sv -----
// Self-checking testbench for the French number word tokenizer: random handshakes and word prediction.
module tb_french_number_word_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;
	import fnw_pkg::*;

	// One digit group as presented on the input channel.
	typedef struct {
		logic       plus;
		logic [2:0] count;
		logic [3:0] th;
		logic [3:0] hu;
		logic [3:0] te;
		logic [3:0] un;
		logic       fin;
	} digit_group_t;

	// One spoken word as expected on the output channel.
	typedef struct {
		word_t code;
		logic  last;
		logic  eom;
	} spoken_word_t;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 24;
	localparam int RANDOM_GROUPS = 243;

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       in_valid        = 1'b0;
	logic       in_ready;
	logic       is_plus         = 1'b0;
	logic [2:0] digit_count     = 3'd0;
	logic [3:0] thousands_digit = 4'd0;
	logic [3:0] hundreds_digit  = 4'd0;
	logic [3:0] tens_digit      = 4'd0;
	logic [3:0] units_digit     = 4'd0;
	logic       final_group     = 1'b0;
	logic       out_valid;
	logic       out_ready       = 1'b0;
	logic [5:0] word_code;
	logic       last_of_group;
	logic       end_of_message;

	digit_group_t pending_groups[$];
	spoken_word_t expected_words[$];

	logic in_accepted  = 1'b0;
	logic out_accepted = 1'b0;
	int   mismatches      = 0;
	int   words_checked   = 0;
	int   total_groups    = 0;
	int   groups_accepted = 0;
	int   plus_accepted   = 0;
	int   groups_rejected = 0;
	int   cycle_count     = 0;
	int   gap_left        = 0;
	int   stall_left      = 0;
	bit   in_burst        = 1'b0;
	bit   out_burst       = 1'b0;

	french_number_word_tokenizer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.is_plus        (is_plus),
		.digit_count    (digit_count),
		.thousands_digit(thousands_digit),
		.hundreds_digit (hundreds_digit),
		.tens_digit     (tens_digit),
		.units_digit    (units_digit),
		.final_group    (final_group),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_code      (word_code),
		.last_of_group  (last_of_group),
		.end_of_message (end_of_message)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	// Units and lead words; the elided form drops the final consonant of six and huit.
	function automatic word_t plain_word(input int d, input bit elided);
		case (d)
			1: return W_UN;
			2: return W_DEUX;
			3: return W_TROIS;
			4: return W_QUATRE;
			5: return W_CINQ;
			6: return elided ? W_SI : W_SIX;
			7: return W_SEPT;
			8: return elided ? W_HUI : W_HUIT;
			9: return W_NEUF;
			default: return W_VIDE;
		endcase
	endfunction

	function automatic word_t teen_word(input int d);
		case (d)
			1: return W_ONZE;
			2: return W_DOUZE;
			3: return W_TREIZE;
			4: return W_QUATORZE;
			5: return W_QUINZE;
			default: return W_SEIZE;
		endcase
	endfunction

	function automatic void expect_word(input word_t code, input logic last, input logic eom);
		spoken_word_t w;
		w.code = code;
		w.last = last;
		w.eom  = eom;
		expected_words.push_back(w);
	endfunction

	// Speak a mille or cent position; a negative digit means the position is absent.
	function automatic void expect_multiple(input int d, input bit higher_zero, input word_t mult);
		if (d == 0) begin
			if (higher_zero)
				expect_word(W_ZERO, 1'b0, 1'b0);
		end else if (d == 1) begin
			expect_word(mult, 1'b0, 1'b0);
		end else if (d >= 2 && d <= 9) begin
			expect_word(plain_word(d, 1'b1), 1'b0, 1'b0);
			expect_word(mult, 1'b0, 1'b0);
		end
	endfunction

	// Queue the words that one accepted group must produce.
	function automatic void expect_group_words(input digit_group_t g);
		int th, hu, te, un;
		bit teen, zt, zh, zte;
		th   = -1;
		hu   = -1;
		te   = -1;
		teen = 1'b0;
		if (g.plus) begin
			expect_word(W_PLUS, 1'b0, 1'b0);
			expect_word(W_VIDE, 1'b1, g.fin);
			return;
		end
		if (g.count < 3'd1 || g.count > 3'd4)
			return;
		un = g.un;
		if (g.count >= 3'd2) te = g.te;
		if (g.count >= 3'd3) hu = g.hu;
		if (g.count == 3'd4) th = g.th;
		zt  = (th <= 0);
		zh  = zt && (hu <= 0);
		zte = zh && (te <= 0);

		expect_multiple(th, 1'b1, W_MILLE);
		expect_multiple(hu, zt, W_CENT);

		// tens position
		case (te)
			0: if (zh) expect_word(W_ZERO, 1'b0, 1'b0);
			1: teen = 1'b1;
			2: begin
				if (un == 0) begin
					expect_word(W_VINGT, 1'b0, 1'b0);
				end else begin
					expect_word(W_VINGTT, 1'b0, 1'b0);
					if (un == 1) expect_word(W_EH, 1'b0, 1'b0);
				end
			end
			3, 4, 5, 6, 7: begin
				expect_word(te == 3 ? W_TRENTE : te == 4 ? W_QUARANTE :
					te == 5 ? W_CINQUANTE : W_SOIXANTE, 1'b0, 1'b0);
				if (un == 1) expect_word(W_EH, 1'b0, 1'b0);
				if (te == 7) teen = 1'b1;
			end
			8, 9: begin
				expect_word(W_QUATREE, 1'b0, 1'b0);
				expect_word(W_VINGT, 1'b0, 1'b0);
				if (te == 9) teen = 1'b1;
			end
			default: ;
		endcase

		// units position
		if (un == 0) begin
			if (zte) expect_word(W_ZERO, 1'b0, 1'b0);
			if (teen) expect_word(W_DIX, 1'b0, 1'b0);
		end else if (un <= 6) begin
			expect_word(teen ? teen_word(un) : plain_word(un, 1'b0), 1'b0, 1'b0);
		end else if (un <= 9) begin
			if (teen) expect_word(un == 7 ? W_DI : W_DIZ, 1'b0, 1'b0);
			expect_word(plain_word(un, 1'b0), 1'b0, 1'b0);
		end
		expect_word(W_VIDE, 1'b1, g.fin);
	endfunction

	task automatic add_group(input logic plus, input logic [2:0] count, input logic [3:0] th,
			input logic [3:0] hu, input logic [3:0] te, input logic [3:0] un, input logic fin);
		digit_group_t g;
		g.plus  = plus;
		g.count = count;
		g.th    = th;
		g.hu    = hu;
		g.te    = te;
		g.un    = un;
		g.fin   = fin;
		pending_groups.push_back(g);
		total_groups++;
	endtask

	// Present groups; hold each until its transfer, then wait a random gap.
	always @(negedge clk) begin : drive_groups
		digit_group_t g;
		if (arst_n && (!in_valid || in_accepted)) begin
			if (gap_left > 0 || pending_groups.size() == 0) begin
				if (gap_left > 0) gap_left--;
				in_valid <= 1'b0;
			end else begin
				g = pending_groups.pop_front();
				in_valid        <= 1'b1;
				is_plus         <= g.plus;
				digit_count     <= g.count;
				thousands_digit <= g.th;
				hundreds_digit  <= g.hu;
				tens_digit      <= g.te;
				units_digit     <= g.un;
				final_group     <= g.fin;
				if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
				gap_left = in_burst ? 0 : $urandom_range(0, 8);
			end
		end
	end

	// Stall the word channel by a random gap after each transfer.
	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (out_accepted) begin
				if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
				stall_left = out_burst ? 0 : $urandom_range(0, 8);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each word transfer against the oldest expectation; predict on group transfers.
	always @(posedge clk) begin : watch_channels
		spoken_word_t w;
		digit_group_t g;
		in_accepted  <= arst_n && in_valid && in_ready;
		out_accepted <= arst_n && out_valid && out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %0d with no word pending", word_code));
				end else begin
					w = expected_words.pop_front();
					if (word_code !== w.code)
						report_mismatch($sformatf("word_code %0d, want %0d", word_code, w.code));
					if (last_of_group !== w.last)
						report_mismatch($sformatf("last_of_group %b, want %b (word %0d)",
							last_of_group, w.last, w.code));
					if (end_of_message !== w.eom)
						report_mismatch($sformatf("end_of_message %b, want %b (word %0d)",
							end_of_message, w.eom, w.code));
					words_checked++;
				end
			end
			if (in_valid && in_ready) begin
				g.plus  = is_plus;
				g.count = digit_count;
				g.th    = thousands_digit;
				g.hu    = hundreds_digit;
				g.te    = tens_digit;
				g.un    = units_digit;
				g.fin   = final_group;
				expect_group_words(g);
				groups_accepted++;
				if (is_plus)
					plus_accepted++;
				else if (digit_count < 3'd1 || digit_count > 3'd4)
					groups_rejected++;
			end
		end
	end

	// End the run if it hangs.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_words.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : run_test
		int counted, roll, pick;
		logic [3:0] d [4];
		logic [2:0] cnt;

		// directed groups: plus signs, extremes, teen and et forms, leading zeros
		add_group(1'b1, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
		add_group(1'b1, 3'd7, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1);
		add_group(1'b0, 3'd1, 4'd9, 4'd9, 4'd9, 4'd0, 1'b0);
		add_group(1'b0, 3'd4, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
		add_group(1'b0, 3'd4, 4'd0, 4'd0, 4'd0, 4'd1, 1'b0);
		add_group(1'b0, 3'd4, 4'd9, 4'd9, 4'd9, 4'd9, 1'b1);
		add_group(1'b0, 3'd4, 4'd1, 4'd0, 4'd0, 4'd0, 1'b0);
		add_group(1'b0, 3'd4, 4'd1, 4'd1, 4'd0, 4'd1, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd2, 4'd1, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd7, 4'd1, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd8, 4'd0, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd9, 4'd1, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd9, 4'd9, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd1, 4'd7, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd1, 4'd0, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd2, 4'd5, 1'b0);
		add_group(1'b0, 3'd3, 4'd0, 4'd7, 4'd7, 4'd7, 1'b0);
		add_group(1'b0, 3'd3, 4'd0, 4'd4, 4'd1, 4'd6, 1'b0);
		add_group(1'b0, 3'd3, 4'd9, 4'd0, 4'd6, 4'd1, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
		// group lengths that are not spoken
		add_group(1'b0, 3'd0, 4'd1, 4'd2, 4'd3, 4'd4, 1'b0);
		add_group(1'b0, 3'd5, 4'd5, 4'd6, 4'd7, 4'd8, 1'b1);
		add_group(1'b0, 3'd7, 4'd9, 4'd9, 4'd9, 4'd9, 1'b1);
		// digits above nine
		add_group(1'b0, 3'd4, 4'd15, 4'd0, 4'd0, 4'd0, 1'b0);
		add_group(1'b0, 3'd3, 4'd0, 4'd10, 4'd2, 4'd11, 1'b0);
		add_group(1'b0, 3'd2, 4'd0, 4'd0, 4'd12, 4'd13, 1'b0);
		add_group(1'b0, 3'd1, 4'd0, 4'd0, 4'd0, 4'd15, 1'b1);

		// random groups: mostly well formed, some plus signs, noise and bad lengths
		counted = 0;
		while (counted < RANDOM_GROUPS) begin
			roll = $urandom_range(0, 99);
			for (int i = 0; i < 4; i++)
				d[i] = 4'($urandom_range(0, 15));
			if (roll < 10) begin
				cnt = 3'($urandom_range(0, 7));
				counted++;
			end else if (roll < 80) begin
				cnt = 3'($urandom_range(1, 4));
				for (int i = 0; i < 4; i++)
					if (i < cnt)
						d[i] = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 9));
				counted++;
			end else if (roll < 90) begin
				cnt = 3'($urandom_range(1, 4));
				counted++;
			end else begin
				pick = $urandom_range(5, 8);
				cnt = (pick == 8) ? 3'd0 : 3'(pick);
				counted++;
			end
			add_group(roll < 10, cnt, d[3], d[2], d[1], d[0], $urandom_range(0, 3) == 0);
		end

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// drain: all groups taken, all words seen, then a quiet margin
		while (groups_accepted < total_groups) @(negedge clk);
		while (expected_words.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d groups (%0d plus signs, %0d bad lengths), %0d words checked",
			groups_accepted, plus_accepted, groups_rejected, words_checked);
		$display("Mismatches: %0d, cycles: %0d", mismatches, cycle_count);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/fnw_pkg.sv
rtl/core/fnw_front.sv
rtl/core/fnw_queue.sv
rtl/core/fnw_back.sv
rtl/core/french_number_word_tokenizer.sv
rtl/core/fnw_checker.sv
tb/tb_french_number_word_tokenizer.sv
